FILE: src/cbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types and constants of the counting Bloom filter core.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int HASH_W        = 64;
  localparam int CFG_W         = 11;
  localparam int MOD_STEP_BITS = 8;
  localparam int MOD_STEPS     = HASH_W / MOD_STEP_BITS;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1024;

  // Request kinds. The unused fourth code behaves as a test.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TEST   = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [HASH_W-1:0] hash_value;
    logic              last_hash;
  } req_item_t;

  typedef struct packed {
    logic is_member;
    logic count_limited;
  } result_item_t;

endpackage

FILE: src/counting_bloom_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_bloom_filter_core
// Counting Bloom filter over a RAM of saturating counters. Each beat brings
// one hash; the last hash of a request produces one result beat.
//
//   Port group   Dir   Handshake                    Beat payload
//   item         in    item_valid / item_ready      req_item_t
//   result       out   result_valid / result_ready  result_item_t
//   cfg          in    cfg_wr_en (no wait)          table_size
//
// An item passes through acceptance, the remainder unit (8 hash bits per
// cycle), one RAM read and one update/write-back.
// After reset a clearing pass writes zero to all TABLE_DEPTH counters,
// one per cycle, and no item is accepted until that pass is done.
// The result register lets the next item in while a result waits; a
// request end stalls only if an earlier result has still not been taken.
// ----------------------------------------------------------------------------
module counting_bloom_filter_core #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int COUNTER_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  cbf_pkg::req_item_t         item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output cbf_pkg::result_item_t      result,
  input  logic                       cfg_wr_en,
  input  logic [cbf_pkg::CFG_W-1:0]  cfg_wr_data
);
  import cbf_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int DIV_W  = ADDR_W + 1;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_MOD    = 5'b00100,
    S_UPDATE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]         table_size;
  logic [ADDR_W-1:0]        clr_addr;
  logic                     zero_seen;
  logic                     limit_seen;
  logic [1:0]               kind;
  logic                     last;
  result_item_t             pend;

  logic                     accept;
  logic [31:0]              eff_size;
  logic [DIV_W-1:0]         divisor;
  logic                     mod_done;
  logic [ADDR_W-1:0]        mod_rem;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [COUNTER_WIDTH-1:0] ram_wdata;
  logic                     ram_re;
  logic [COUNTER_WIDTH-1:0] ram_rdata;

  logic                     upd_we;
  logic [COUNTER_WIDTH-1:0] upd_val;
  logic                     lim;
  logic                     zero_next;
  logic                     limit_next;
  result_item_t             res_calc;
  logic                     slot_free;
  logic                     emit;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;
  assign emit       = slot_free && ((state == S_UPDATE && last) || state == S_EMIT);

  // Table size zero acts as one; sizes past the table clamp to its depth.
  always_comb begin
    eff_size = 32'(table_size);
    if (eff_size == 32'd0) begin
      eff_size = 32'd1;
    end else if (eff_size > 32'(TABLE_DEPTH)) begin
      eff_size = 32'(TABLE_DEPTH);
    end
  end
  assign divisor = eff_size[DIV_W-1:0];

  cbf_mod #(
    .REM_W(ADDR_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (item.hash_value),
    .divisor  (divisor),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  // Counter update from the word read back from the RAM.
  always_comb begin
    upd_we  = 1'b0;
    upd_val = ram_rdata;
    lim     = 1'b0;
    unique case (kind)
      REQ_ADD: begin
        if (&ram_rdata) begin
          lim = 1'b1;
        end else begin
          upd_we  = 1'b1;
          upd_val = ram_rdata + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (ram_rdata == '0) begin
          lim = 1'b1;
        end else begin
          upd_we  = 1'b1;
          upd_val = ram_rdata - 1'b1;
        end
      end
      default: begin
      end
    endcase
    zero_next  = zero_seen || (ram_rdata == '0);
    limit_next = limit_seen || lim;
    if (kind == REQ_ADD || kind == REQ_REMOVE) begin
      res_calc.is_member     = 1'b0;
      res_calc.count_limited = limit_next;
    end else begin
      res_calc.is_member     = !zero_next;
      res_calc.count_limited = 1'b0;
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_UPDATE) && upd_we;
      ram_waddr = mod_rem;
      ram_wdata = upd_val;
    end
  end
  assign ram_re = (state == S_MOD) && mod_done;

  cbf_ram #(
    .WIDTH(COUNTER_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(mod_rem),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      table_size   <= TABLE_SIZE_RESET;
      zero_seen    <= 1'b0;
      limit_seen   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_size <= cfg_wr_data;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (last) begin
            zero_seen  <= 1'b0;
            limit_seen <= 1'b0;
            if (slot_free) begin
              state <= S_IDLE;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            zero_seen  <= zero_next;
            limit_seen <= limit_next;
            state      <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= item.req_type;
      last <= item.last_hash;
    end
    if (state == S_UPDATE && last) begin
      pend <= res_calc;
      if (slot_free) begin
        result <= res_calc;
      end
    end else if (state == S_EMIT && slot_free) begin
      result <= pend;
    end
  end

  // Every accepted item is followed by a done from the remainder unit.
  a_mod_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##9 mod_done)
    else $error("remainder unit did not finish on schedule");

  // Only adds and removes ever write a counter back.
  a_write_kind: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_UPDATE) |-> (kind == REQ_ADD || kind == REQ_REMOVE))
    else $error("counter written by a test request");

  // No counter is written while waiting for an item or for the result slot.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_EMIT) |-> !ram_we)
    else $error("RAM write outside clear or update");

  // A new result appears only at the end of a request.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |->
      (($past(state) == S_UPDATE && $past(last)) || $past(state) == S_EMIT))
    else $error("result raised without a finished request");

endmodule

FILE: src/cbf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/cbf_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_mod
// Iterative remainder unit: reduces a 64-bit hash modulo a narrow divisor,
// several quotient bits per cycle.
// ----------------------------------------------------------------------------
module cbf_mod #(
  parameter int REM_W = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cbf_pkg::HASH_W-1:0] dividend,
  input  logic [REM_W:0]            divisor,
  output logic                      done,
  output logic [REM_W-1:0]          remainder
);
  import cbf_pkg::*;

  localparam int DIV_W = REM_W + 1;
  localparam int CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  logic              active;
  logic [CNT_W-1:0]  cnt;
  logic [HASH_W-1:0] shreg;
  logic [DIV_W-1:0]  div;
  logic [REM_W-1:0]  rem_next;

  // Restoring steps: the partial remainder always stays below the divisor,
  // so it fits in REM_W bits between steps.
  always_comb begin
    logic [DIV_W-1:0] r;
    r = {1'b0, remainder};
    for (int i = 0; i < MOD_STEP_BITS; i++) begin
      r = {r[DIV_W-2:0], shreg[HASH_W-1-i]};
      if (r >= div) begin
        r = r - div;
      end
    end
    rem_next = r[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      if (start) begin
        active <= 1'b1;
        done   <= 1'b0;
      end else if (active && cnt == CNT_W'(MOD_STEPS - 1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      div       <= divisor;
      remainder <= '0;
      cnt       <= '0;
    end else if (active) begin
      shreg     <= shreg << MOD_STEP_BITS;
      remainder <= rem_next;
      cnt       <= cnt + 1'b1;
    end
  end

endmodule

FILE: test/tb_counting_bloom_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counting_bloom_filter_core
// Self-checking bench for the counting Bloom filter core. A queue-fed driver
// offers hash beats with random gaps, and a monitor predicts every result from
// a local copy of the counter table. The run covers directed corner cases and
// then random add, remove, test and unused-code requests over several table sizes.
// ----------------------------------------------------------------------------
module tb_counting_bloom_filter_core;
  import cbf_pkg::*;

  localparam int TABLE_DEPTH   = 1024;
  localparam int COUNTER_WIDTH = 8;
  localparam logic [COUNTER_WIDTH-1:0] COUNT_TOP = '1;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int MAX_IDLE     = 13;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [3:0][HASH_W-1:0] hashes;
    logic [2:0]             count;
  } element_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  req_item_t          item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_item_t       result;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;

  counting_bloom_filter_core #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the filter state.
  logic [COUNTER_WIDTH-1:0] counter_copy [TABLE_DEPTH];
  logic                     zero_seen_copy = 1'b0;
  logic                     limit_seen_copy = 1'b0;
  logic [CFG_W-1:0]         table_size_copy = TABLE_SIZE_RESET;

  result_item_t expected_results [$];
  req_item_t    pending_beats [$];
  element_t     stored_elements [$];

  int   errors = 0;
  int   cycles = 0;
  logic item_taken = 1'b0;
  logic result_taken = 1'b0;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   send_count = 0;
  int   recv_count = 0;
  bit   send_burst = 1'b0;
  bit   recv_burst = 1'b0;
  int   hold_left = 0;
  int   hold_request = 0;
  int   hold_served = 0;

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) counter_copy[i] = '0;
  end

  function automatic int idle_draw(bit burst);
    return burst ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  // Applies one hash beat to the local table and queues a result if it ends a request.
  task automatic update_filter_copy(input req_item_t beat);
    longint unsigned          span;
    int                       addr;
    logic [COUNTER_WIDTH-1:0] cnt;
    result_item_t             res;
    span = (table_size_copy == 0) ? 1 : longint'(table_size_copy);
    if (span > TABLE_DEPTH) span = TABLE_DEPTH;
    addr = int'(beat.hash_value % span);
    cnt = counter_copy[addr];
    if (cnt == 0) zero_seen_copy = 1'b1;
    case (beat.req_type)
      REQ_ADD: begin
        if (cnt == COUNT_TOP) limit_seen_copy = 1'b1;
        else counter_copy[addr] = cnt + 1'b1;
      end
      REQ_REMOVE: begin
        if (cnt == 0) limit_seen_copy = 1'b1;
        else counter_copy[addr] = cnt - 1'b1;
      end
      default: ;
    endcase
    if (beat.last_hash) begin
      if (beat.req_type == REQ_ADD || beat.req_type == REQ_REMOVE) begin
        res.is_member     = 1'b0;
        res.count_limited = limit_seen_copy;
      end else begin
        res.is_member     = !zero_seen_copy;
        res.count_limited = 1'b0;
      end
      expected_results.push_back(res);
      zero_seen_copy  = 1'b0;
      limit_seen_copy = 1'b0;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_item_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    item_taken   <= !rst && item_valid && item_ready;
    result_taken <= !rst && result_valid && result_ready;
    if (!rst && item_valid && item_ready) update_filter_copy(item);
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with none expected: is_member=%0b count_limited=%0b",
               result.is_member, result.count_limited);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.is_member !== want.is_member) begin
          $error("is_member: expected %0b, got %0b", want.is_member, result.is_member);
          errors++;
        end
        if (result.count_limited !== want.count_limited) begin
          $error("count_limited: expected %0b, got %0b",
                 want.count_limited, result.count_limited);
          errors++;
        end
      end
    end
  end

  // Valid drops only after the beat was taken; a zero gap keeps it high.
  always @(negedge clk) begin : sender
    logic      offer;
    req_item_t next_beat;
    offer = item_valid;
    next_beat = item;
    if (item_valid && item_taken) offer = 1'b0;
    if (!rst && !offer) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (pending_beats.size() > 0) begin
        next_beat = pending_beats.pop_front();
        offer = 1'b1;
        if (send_count % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
        send_count++;
        send_wait = idle_draw(send_burst);
      end
    end
    item_valid <= offer;
    item <= next_beat;
  end

  always @(negedge clk) begin : receiver
    if (hold_served != hold_request) begin
      hold_served = hold_request;
      hold_left = LONG_HOLD;
    end
    if (result_taken) begin
      if (recv_count % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      recv_count++;
      recv_wait = idle_draw(recv_burst);
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  function automatic logic [HASH_W-1:0] random_hash();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return {$urandom, $urandom};
    if (pick < 85) return HASH_W'($urandom_range(0, 2047));
    return ~HASH_W'($urandom_range(0, 2047));
  endfunction

  function automatic element_t fresh_element();
    element_t el;
    el.count = 3'($urandom_range(1, 4));
    for (int i = 0; i < 4; i++) el.hashes[i] = random_hash();
    return el;
  endfunction

  task automatic queue_beat(input logic [1:0] kind, input logic [HASH_W-1:0] hash,
                            input logic last);
    req_item_t beat;
    beat.req_type   = kind;
    beat.hash_value = hash;
    beat.last_hash  = last;
    pending_beats.push_back(beat);
  endtask

  task automatic queue_element(input logic [1:0] kind, input element_t el);
    for (int i = 0; i < el.count; i++) queue_beat(kind, el.hashes[i], i == el.count - 1);
  endtask

  // Mostly whole requests on fresh or remembered elements; the rest mixes kinds per beat.
  task automatic queue_random_requests(input int n_beats, input int add_w, input int rem_w);
    int          queued;
    int unsigned roll;
    int          idx;
    int          n;
    element_t    el;
    queued = 0;
    while (queued < n_beats) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        roll = $urandom_range(0, 99);
        if (roll < add_w) begin
          el = fresh_element();
          stored_elements.push_back(el);
          queue_element(REQ_ADD, el);
        end else if (roll < add_w + rem_w) begin
          if (stored_elements.size() > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, stored_elements.size() - 1);
            el = stored_elements[idx];
            stored_elements.delete(idx);
          end else begin
            el = fresh_element();
          end
          queue_element(REQ_REMOVE, el);
        end else begin
          if (stored_elements.size() > 0 && $urandom_range(0, 1) != 0)
            el = stored_elements[$urandom_range(0, stored_elements.size() - 1)];
          else
            el = fresh_element();
          queue_element(REQ_TEST, el);
        end
        queued += el.count;
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) queue_beat(2'($urandom_range(0, 3)), random_hash(), i == n - 1);
        queued += n;
      end
    end
  endtask

  // A request that ends without a result may still be in the remainder unit,
  // so the bench lets the core drain before the table size may change.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] size, input int n_beats,
                           input int add_w, input int rem_w, input bit long_hold);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    table_size_copy = size;
    queue_random_requests(n_beats, add_w, rem_w);
    if (long_hold) hold_request++;
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset table size.
    queue_beat(REQ_TEST, 64'd0, 1'b1);
    queue_beat(REQ_ADD, 64'd0, 1'b0);
    queue_beat(REQ_ADD, 64'd1023, 1'b0);
    queue_beat(REQ_ADD, '1, 1'b1);
    queue_beat(REQ_TEST, 64'd0, 1'b0);
    queue_beat(REQ_TEST, 64'd1024, 1'b0);
    queue_beat(REQ_TEST, '1, 1'b1);
    queue_beat(REQ_REMOVE, 64'd5, 1'b1);
    queue_beat(REQ_REMOVE, 64'd2048, 1'b1);
    queue_beat(REQ_SPARE, 64'd1023, 1'b1);
    queue_beat(REQ_SPARE, 64'd0, 1'b1);
    // Mixed kinds in one request: the last beat decides the result shape.
    queue_beat(REQ_ADD, 64'd7, 1'b0);
    queue_beat(REQ_REMOVE, 64'd9, 1'b0);
    queue_beat(REQ_TEST, 64'd7, 1'b1);
    queue_beat(REQ_TEST, 64'd100, 1'b0);
    queue_beat(REQ_ADD, 64'h8000_0000_0000_0000, 1'b1);
    queue_beat(REQ_TEST, 64'h8000_0000_0000_0000, 1'b1);
    queue_beat(REQ_REMOVE, 64'h8000_0000_0000_0000, 1'b0);
    queue_beat(REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    queue_beat(REQ_TEST, 64'h5555_5555_5555_5555, 1'b0);
    queue_beat(REQ_REMOVE, 64'hFFFF_FFFF_FFFF_FC00, 1'b1);
    wait_idle();

    // A single counter fills to saturation, then later removals try to take it below zero.
    run_phase(CFG_W'(1), 400, 80, 10, 1'b1);
    run_phase(CFG_W'(2047), 160, 40, 30, 1'b0);
    run_phase(CFG_W'(3), 140, 45, 35, 1'b1);
    run_phase(CFG_W'(0), 160, 10, 80, 1'b0);
    run_phase(CFG_W'(1024), 200, 40, 30, 1'b0);
    run_phase(CFG_W'($urandom_range(4, 200)), 120, 40, 30, 1'b0);
    run_phase(CFG_W'(1), 150, 5, 85, 1'b0);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: counting_bloom_filter_core.f
src/cbf_pkg.sv
src/cbf_ram.sv
src/cbf_mod.sv
src/counting_bloom_filter_core.sv
test/tb_counting_bloom_filter_core.sv
